// ----- design/bounded_array_list_engine_macros.svh -----
// ---------------------------------------------------------------------------
// Bounded array list engine: assertion macros
// Shared concurrent assertion helpers, clocked on clk_i and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef BOUNDED_ARRAY_LIST_ENGINE_MACROS_SVH
`define BOUNDED_ARRAY_LIST_ENGINE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define BALE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define BALE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BALE_ASSERT_IMPL(lbl, ante, cons, msg)
`define BALE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- design/bale_pkg.sv -----
// ---------------------------------------------------------------------------
// Bounded array list engine package
// Sizes, command and status codes, and the cell control type.
// ---------------------------------------------------------------------------
package bale_pkg;

  localparam int unsigned Depth = 16;
  localparam int unsigned IdxW  = $clog2(Depth);
  localparam int unsigned LenW  = $clog2(Depth + 1);
  localparam int unsigned DataW = 32;
  localparam int unsigned CmdW  = 3;
  localparam int unsigned PosW  = 5;

  typedef enum logic [CmdW-1:0] {
    CMD_READ      = 3'd0,
    CMD_WRITE     = 3'd1,
    CMD_INSERT    = 3'd2,
    CMD_REMOVE_AT = 3'd3,
    CMD_FIND      = 3'd4,
    CMD_REMOVE_V  = 3'd5,
    CMD_CLEAR     = 3'd6,
    CMD_DROP      = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BADPOS   = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DROP
  } state_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_PREV,
    CELL_NEXT
  } cell_op_e;

  typedef struct packed {
    cell_op_e             op;
    logic [DataW-1:0]     wdata;
  } cell_ctrl_t;

endpackage

// ----- design/bale_cell.sv -----
// ---------------------------------------------------------------------------
// List cell
// Holds one list entry; loads a new value or takes its neighbour's entry.
// ---------------------------------------------------------------------------
module bale_cell (
  input  logic                         clk_i,
  input  bale_pkg::cell_ctrl_t         ctrl_i,
  input  logic [bale_pkg::DataW-1:0]   prev_i,
  input  logic [bale_pkg::DataW-1:0]   next_i,
  input  logic [bale_pkg::DataW-1:0]   key_i,
  output logic [bale_pkg::DataW-1:0]   data_o,
  output logic                         match_o
);
  import bale_pkg::*;

  logic [DataW-1:0] data_q;
  logic [DataW-1:0] data_d;

  always_comb begin
    case (ctrl_i.op)
      CELL_LOAD: data_d = ctrl_i.wdata;
      CELL_PREV: data_d = prev_i;
      CELL_NEXT: data_d = next_i;
      default:   data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign match_o = (data_q == key_i);

endmodule

// ----- design/bounded_array_list_engine.sv -----
// ---------------------------------------------------------------------------
// Bounded array list engine
// Ordered list of signed 32-bit entries kept in a row of cells, one entry per
// cell in logical order; inserts and removals shift the row by one place.
// ---------------------------------------------------------------------------
// A command is registered and executed in S_EXEC, and its result is registered
// once the output is free; drop_first first shifts the row in S_DROP, one place per dropped entry.
// The input is stalled while a command executes, so a new command is taken only
// once the engine is back in S_IDLE; drop_first also holds it while it drops entries.
// Reset clears the length and the control state; cell contents are undefined.
module bounded_array_list_engine (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [2:0]                   command_i,
  input  logic [4:0]                   position_i,
  input  logic signed [31:0]           value_i,
  input  logic [4:0]                   drop_count_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   status_o,
  output logic signed [31:0]           read_value_o,
  output logic [3:0]                   found_position_o,
  output logic [4:0]                   list_length_o
);
  import bale_pkg::*;

  `include "bounded_array_list_engine_macros.svh"

  state_e            state_q, state_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [LenW-1:0]   cnt_q, cnt_d;
  cmd_e              cmd_q;
  logic [PosW-1:0]   pos_q;
  logic [DataW-1:0]  val_q;
  logic [PosW-1:0]   dcnt_q;

  logic              out_valid_q;
  status_e           res_status_q, res_status;
  logic [DataW-1:0]  res_rdata_q, res_rdata;
  logic [IdxW-1:0]   res_fpos_q, res_fpos;
  logic [LenW-1:0]   res_len_q, res_len;
  logic              res_load;

  logic              in_xfer;
  logic              out_free;

  cell_ctrl_t        cell_ctrl  [Depth];
  logic [DataW-1:0]  cell_data  [Depth];
  logic [DataW-1:0]  cell_prev  [Depth];
  logic [DataW-1:0]  cell_next  [Depth];
  logic [Depth-1:0]  cell_match;

  logic              hit;
  logic [IdxW-1:0]   hit_idx;
  logic              pos_lt_len;
  logic              pos_le_len;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // Row of cells, each wired to its neighbours.
  for (genvar k = 0; k < Depth; k++) begin : g_cell
    if (k == 0) begin : g_first
      assign cell_prev[k] = cell_data[k];
    end else begin : g_mid_prev
      assign cell_prev[k] = cell_data[k-1];
    end
    if (k == Depth - 1) begin : g_last
      assign cell_next[k] = cell_data[k];
    end else begin : g_mid_next
      assign cell_next[k] = cell_data[k+1];
    end

    bale_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl[k]),
      .prev_i  (cell_prev[k]),
      .next_i  (cell_next[k]),
      .key_i   (val_q),
      .data_o  (cell_data[k]),
      .match_o (cell_match[k])
    );
  end

  // First live cell that holds the search value.
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int k = Depth - 1; k >= 0; k--) begin
      if (cell_match[k] && (k < 32'(len_q))) begin
        hit     = 1'b1;
        hit_idx = IdxW'(k);
      end
    end
  end

  assign pos_lt_len = (32'(pos_q) <  32'(len_q));
  assign pos_le_len = (32'(pos_q) <= 32'(len_q));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (cmd_q == CMD_DROP) begin
          state_d = S_DROP;
        end else if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_DROP: begin
        if ((cnt_q == '0) && out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Cell control, length update and result.
  always_comb begin
    for (int k = 0; k < Depth; k++) begin
      cell_ctrl[k].op    = CELL_HOLD;
      cell_ctrl[k].wdata = val_q;
    end
    len_d      = len_q;
    cnt_d      = cnt_q;
    res_load   = 1'b0;
    res_status = ST_OK;
    res_rdata  = '0;
    res_fpos   = '0;
    res_len    = len_q;

    unique case (state_q)
      S_EXEC: begin
        if (cmd_q == CMD_DROP) begin
          cnt_d = (32'(dcnt_q) > 32'(len_q)) ? len_q : LenW'(dcnt_q);
        end else if (out_free) begin
          res_load = 1'b1;
          case (cmd_q)
            CMD_READ: begin
              if (pos_lt_len) res_rdata = cell_data[pos_q[IdxW-1:0]];
              else            res_status = ST_BADPOS;
            end
            CMD_WRITE: begin
              if (pos_lt_len) cell_ctrl[pos_q[IdxW-1:0]].op = CELL_LOAD;
              else            res_status = ST_BADPOS;
            end
            CMD_INSERT: begin
              if (!pos_le_len) begin
                res_status = ST_BADPOS;
              end else if (32'(len_q) >= Depth) begin
                res_status = ST_FULL;
              end else begin
                for (int k = 0; k < Depth; k++) begin
                  if (k > 32'(pos_q))       cell_ctrl[k].op = CELL_PREV;
                  else if (k == 32'(pos_q)) cell_ctrl[k].op = CELL_LOAD;
                end
                len_d = len_q + LenW'(1);
              end
            end
            CMD_REMOVE_AT: begin
              if (pos_lt_len) begin
                res_rdata = cell_data[pos_q[IdxW-1:0]];
                for (int k = 0; k < Depth - 1; k++) begin
                  if (k >= 32'(pos_q)) cell_ctrl[k].op = CELL_NEXT;
                end
                len_d = len_q - LenW'(1);
              end else begin
                res_status = ST_BADPOS;
              end
            end
            CMD_FIND: begin
              if (hit) res_fpos   = hit_idx;
              else     res_status = ST_NOTFOUND;
            end
            CMD_REMOVE_V: begin
              if (hit) begin
                res_fpos  = hit_idx;
                res_rdata = val_q;
                for (int k = 0; k < Depth - 1; k++) begin
                  if (k >= 32'(hit_idx)) cell_ctrl[k].op = CELL_NEXT;
                end
                len_d = len_q - LenW'(1);
              end else begin
                res_status = ST_NOTFOUND;
              end
            end
            CMD_CLEAR: len_d = '0;
            default: ;
          endcase
          res_len = len_d;
        end
      end
      S_DROP: begin
        // The row moves down one place per cycle until the count runs out.
        if (cnt_q != '0) begin
          for (int k = 0; k < Depth - 1; k++) begin
            cell_ctrl[k].op = CELL_NEXT;
          end
          len_d = len_q - LenW'(1);
          cnt_d = cnt_q - LenW'(1);
        end else if (out_free) begin
          res_load = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      if (res_load)        out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q  <= cmd_e'(command_i);
      pos_q  <= position_i;
      val_q  <= DataW'(value_i);
      dcnt_q <= drop_count_i;
    end
    if (res_load) begin
      res_status_q <= res_status;
      res_rdata_q  <= res_rdata;
      res_fpos_q   <= res_fpos;
      res_len_q    <= res_len;
    end
  end

  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign status_o         = 2'(res_status_q);
  assign read_value_o     = 32'(res_rdata_q);
  assign found_position_o = 4'(res_fpos_q);
  assign list_length_o    = 5'(res_len_q);

  `BALE_ASSERT_IMPL(a_len_bound, 1'b1, len_q <= LenW'(Depth), "list length beyond depth")
  `BALE_ASSERT_IMPL(a_err_zero, out_valid_q && (res_status_q != ST_OK), res_rdata_q == '0, "nonzero read value with error status")
  `BALE_ASSERT_NEXT(a_accept_exec, in_xfer, state_q == S_EXEC, "accepted command not executed")
  `BALE_ASSERT_NEXT(a_drop_step, (state_q == S_DROP) && (cnt_q != '0), len_q == $past(len_q) - LenW'(1), "drop step did not shorten list")

endmodule

// ----- bench/bale_list_checker.sv -----
// ---------------------------------------------------------------------------
// Bounded array list engine: transfer checker
// Watches both channels of the engine. It keeps its own copy of the list and
// works out the result of every accepted command. It then compares each
// result transfer with the oldest outstanding prediction, field by field.
// ---------------------------------------------------------------------------
module bale_list_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [2:0]         command_i,
  input  logic [4:0]         position_i,
  input  logic signed [31:0] value_i,
  input  logic [4:0]         drop_count_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [1:0]         status_i,
  input  logic signed [31:0] read_value_i,
  input  logic [3:0]         found_position_i,
  input  logic [4:0]         list_length_i,
  output int                 mismatch_count_o,
  output int                 pending_o,
  output int                 checked_o,
  output int                 flagged_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import bale_pkg::*;

  typedef struct packed {
    status_e           status;
    logic signed [31:0] read_value;
    logic [3:0]         found_position;
    logic [4:0]         list_length;
  } list_result_t;

  // The list in logical order; entry 0 is the head.
  logic signed [31:0] list_entries_q[$];
  list_result_t       expected_results_q[$];
  int                 mismatches;
  int                 checked;
  int                 flagged;

  initial begin
    mismatches = 0;
    checked    = 0;
    flagged    = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  function automatic list_result_t apply_command(input cmd_e cmd, input logic [4:0] pos,
                                                 input logic signed [31:0] val,
                                                 input logic [4:0] cnt);
    list_result_t res;
    int           len;
    int           hit;
    int           drop;
    int           k;
    res.status         = ST_OK;
    res.read_value     = '0;
    res.found_position = '0;
    len = list_entries_q.size();
    hit = -1;
    case (cmd)
      CMD_READ: begin
        if (int'(pos) >= len) res.status = ST_BADPOS;
        else res.read_value = list_entries_q[pos];
      end
      CMD_WRITE: begin
        if (int'(pos) >= len) res.status = ST_BADPOS;
        else list_entries_q[pos] = val;
      end
      CMD_INSERT: begin
        // The position is checked before the list is found full.
        if (int'(pos) > len) res.status = ST_BADPOS;
        else if (len >= Depth) res.status = ST_FULL;
        else list_entries_q.insert(pos, val);
      end
      CMD_REMOVE_AT: begin
        if (int'(pos) >= len) res.status = ST_BADPOS;
        else begin
          res.read_value = list_entries_q[pos];
          list_entries_q.delete(pos);
        end
      end
      CMD_FIND, CMD_REMOVE_V: begin
        for (k = 0; k < len; k++)
          if (hit < 0 && list_entries_q[k] == val) hit = k;
        if (hit < 0) res.status = ST_NOTFOUND;
        else begin
          res.found_position = hit[3:0];
          if (cmd == CMD_REMOVE_V) begin
            res.read_value = val;
            list_entries_q.delete(hit);
          end
        end
      end
      CMD_CLEAR: list_entries_q.delete();
      default: begin
        drop = (int'(cnt) > len) ? len : int'(cnt);
        for (k = 0; k < drop; k++) void'(list_entries_q.pop_front());
      end
    endcase
    res.list_length = 5'(list_entries_q.size());
    return res;
  endfunction

  always @(posedge clk_i) begin : monitor
    list_result_t want;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_results_q.size() == 0) begin
          report_mismatch("result with nothing outstanding", {30'b0, status_i}, '0);
        end else begin
          want = expected_results_q.pop_front();
          checked++;
          if (status_i !== want.status)
            report_mismatch("status", {30'b0, status_i}, {30'b0, want.status});
          if (read_value_i !== want.read_value)
            report_mismatch("read_value", read_value_i, want.read_value);
          if (found_position_i !== want.found_position)
            report_mismatch("found_position", {28'b0, found_position_i},
                            {28'b0, want.found_position});
          if (list_length_i !== want.list_length)
            report_mismatch("list_length", {27'b0, list_length_i}, {27'b0, want.list_length});
        end
      end
      if (in_valid_i && !in_stall_i) begin
        want = apply_command(cmd_e'(command_i), position_i, value_i, drop_count_i);
        if (want.status != ST_OK) flagged++;
        expected_results_q.push_back(want);
      end
    end
    mismatch_count_o <= mismatches;
    pending_o        <= expected_results_q.size();
    checked_o        <= checked;
    flagged_o        <= flagged;
  end

endmodule

// ----- bench/tb_bounded_array_list_engine.sv -----
// ---------------------------------------------------------------------------
// Bounded array list engine testbench
// Drives a directed sequence through the empty, full and boundary cases. It
// then drives random commands in phases that alternately fill and drain the
// list, with random idling on both channels and one long output hold-off.
// The checker beside the engine predicts and compares every result.
// ---------------------------------------------------------------------------
module tb_bounded_array_list_engine;
  timeunit 1ns;
  timeprecision 1ps;
  import bale_pkg::*;

  localparam int RandomItems   = 1022;
  localparam int TailItems     = 150;
  localparam int HoldOffStart  = 1500;
  localparam int HoldOffCycles = 64;
  localparam int WatchdogLimit = 1000;
  localparam int DrainCycles   = 40;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [2:0]         command_i;
  logic [4:0]         position_i;
  logic signed [31:0] value_i;
  logic [4:0]         drop_count_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [1:0]         status_o;
  logic signed [31:0] read_value_o;
  logic [3:0]         found_position_o;
  logic [4:0]         list_length_o;

  int   mismatch_count;
  int   pending_results;
  int   results_checked;
  int   results_flagged;
  logic tail_phase;
  int   sent_per_command[8];
  logic [31:0] value_pool[6];

  bounded_array_list_engine DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .command_i        (command_i),
    .position_i       (position_i),
    .value_i          (value_i),
    .drop_count_i     (drop_count_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .read_value_o     (read_value_o),
    .found_position_o (found_position_o),
    .list_length_o    (list_length_o)
  );

  bale_list_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .command_i        (command_i),
    .position_i       (position_i),
    .value_i          (value_i),
    .drop_count_i     (drop_count_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_i         (status_o),
    .read_value_i     (read_value_o),
    .found_position_i (found_position_o),
    .list_length_i    (list_length_o),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_results),
    .checked_o        (results_checked),
    .flagged_o        (results_flagged)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Offers one command and holds it until the engine takes the transfer.
  task automatic send_command(input cmd_e cmd, input logic [4:0] pos,
                              input logic [31:0] val, input logic [4:0] cnt,
                              input bit allow_gap);
    if (allow_gap && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    position_i   <= pos;
    value_i      <= val;
    drop_count_i <= cnt;
    sent_per_command[int'(cmd)]++;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Filling phases favour inserts, draining phases favour removals.
  function automatic cmd_e pick_command(input bit filling);
    int roll;
    roll = $urandom_range(0, 99);
    if (filling) begin
      if (roll < 45) return CMD_INSERT;
      if (roll < 55) return CMD_WRITE;
      if (roll < 65) return CMD_READ;
      if (roll < 75) return CMD_FIND;
      if (roll < 83) return CMD_REMOVE_AT;
      if (roll < 91) return CMD_REMOVE_V;
      if (roll < 97) return CMD_DROP;
      return CMD_CLEAR;
    end
    if (roll < 15) return CMD_INSERT;
    if (roll < 25) return CMD_WRITE;
    if (roll < 37) return CMD_READ;
    if (roll < 49) return CMD_FIND;
    if (roll < 69) return CMD_REMOVE_AT;
    if (roll < 89) return CMD_REMOVE_V;
    if (roll < 98) return CMD_DROP;
    return CMD_CLEAR;
  endfunction

  // The receiver stalls in short bursts, once for a long stretch so that the
  // engine backs up, and not at all in some windows and in the tail.
  initial begin : receiver
    int cycle_no;
    int stall_left;
    cycle_no   = 0;
    stall_left = 0;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      cycle_no++;
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (cycle_no == HoldOffStart) begin
        stall_left = HoldOffCycles - 1;
        out_stall_i <= 1'b1;
      end else if (!tail_phase && (cycle_no % 700) < 550 && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 2);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no transfer for %0d cycles", WatchdogLimit);
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    int          k;
    bit          gaps_on;
    logic [31:0] val;
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    command_i    <= CMD_READ;
    position_i   <= '0;
    value_i      <= '0;
    drop_count_i <= '0;
    tail_phase   <= 1'b0;
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7FFF_FFFF;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hFFFF_FFFF;
    value_pool[4] = $urandom;
    value_pool[5] = $urandom;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty list: every position is out of range and nothing can be found.
    send_command(CMD_READ, 5'd31, 32'h0, 5'd0, 1'b1);
    send_command(CMD_INSERT, 5'd1, 32'h1234_5678, 5'd0, 1'b1);
    send_command(CMD_FIND, 5'd0, 32'h0, 5'd0, 1'b1);
    send_command(CMD_DROP, 5'd0, 32'h0, 5'd31, 1'b1);
    // Fill to the top with the extreme values at both ends.
    for (k = 0; k < Depth; k++) begin
      if (k == 0) val = 32'h8000_0000;
      else if (k == Depth - 1) val = 32'h7FFF_FFFF;
      else if (k == 1) val = 32'h0;
      else if (k == 2) val = 32'hFFFF_FFFF;
      else val = $urandom;
      send_command(CMD_INSERT, k[4:0], val, 5'd0, 1'b1);
    end
    send_command(CMD_INSERT, 5'd0, 32'hDEAD_BEEF, 5'd0, 1'b1);
    send_command(CMD_INSERT, 5'd17, 32'hDEAD_BEEF, 5'd0, 1'b1);
    send_command(CMD_FIND, 5'd0, 32'h7FFF_FFFF, 5'd0, 1'b1);
    // Dropping from the head shifts the remaining entries toward cell 0, so
    // the next insert appends at the new end of the shortened list.
    send_command(CMD_DROP, 5'd0, 32'h0, 5'd3, 1'b1);
    send_command(CMD_INSERT, 5'd13, 32'h5A5A_A5A5, 5'd0, 1'b1);
    send_command(CMD_WRITE, 5'd0, 32'hFFFF_FFFF, 5'd0, 1'b1);
    send_command(CMD_REMOVE_AT, 5'd13, 32'h0, 5'd0, 1'b1);
    send_command(CMD_REMOVE_V, 5'd0, 32'h7FFF_FFFF, 5'd0, 1'b1);
    send_command(CMD_CLEAR, 5'd31, 32'hFFFF_FFFF, 5'd31, 1'b1);

    for (k = 0; k < RandomItems; k++) begin
      if (k == RandomItems - TailItems) tail_phase <= 1'b1;
      gaps_on = (k < RandomItems - TailItems) && !(k >= 400 && k < 500);
      if ($urandom_range(0, 29) == 0) value_pool[$urandom_range(0, 5)] = $urandom;
      val = ($urandom_range(0, 3) != 0) ? value_pool[$urandom_range(0, 5)] : $urandom;
      send_command(pick_command(((k / 40) % 2) == 0),
                   ($urandom_range(0, 9) < 7) ? 5'($urandom_range(0, 16)) :
                   ($urandom_range(0, 1) == 0) ? 5'($urandom_range(0, 3)) :
                                                 5'($urandom_range(0, 31)),
                   val,
                   ($urandom_range(0, 4) != 0) ? 5'($urandom_range(0, 3)) :
                                                 5'($urandom_range(0, 31)),
                   gaps_on);
    end
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("summary: %0d results compared, %0d of them carried an error status",
             results_checked, results_flagged);
    $display({"summary: read %0d write %0d insert %0d remove_at %0d find %0d",
              " remove_value %0d clear %0d drop_first %0d"},
             sent_per_command[CMD_READ], sent_per_command[CMD_WRITE],
             sent_per_command[CMD_INSERT], sent_per_command[CMD_REMOVE_AT],
             sent_per_command[CMD_FIND], sent_per_command[CMD_REMOVE_V],
             sent_per_command[CMD_CLEAR], sent_per_command[CMD_DROP]);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("status: fail");
    end
    $finish;
  end

endmodule
